// ===== src/pcm_pkg.sv =====
// Package with the shared types, codes and constants of the point constraint block.
`timescale 1ns / 1ps
package pcm_pkg;

  localparam int FRAC_BITS = 23;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_COMBINE = 2'd0,
    OP_PROJECT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Constraint kinds and counts.
  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_PLANE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_FIXED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]   opcode;
    logic [1:0]   con_kind;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]   dof_removed;
  } out_item_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_MUL,
    CMD_DOT,
    CMD_CROSS,
    CMD_SQ,
    CMD_SQRT,
    CMD_DIV,
    CMD_PROJ_MUL,
    CMD_PROJ_OUT,
    CMD_COMMIT
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DOT,
    ST_DECIDE,
    ST_CROSS,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_PMUL,
    ST_POUT,
    ST_OUT
  } state_t;

  // Control bundle from controller to datapath.
  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] lane;
    logic       start_unit;
  } ctrl_t;

  // Status bundle from datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] kind;
    logic [1:0] count;
    logic       unit_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== src/pcm_datapath.sv =====
// Datapath of the point constraint block: state, products, square root and divider.
`timescale 1ns / 1ps
module pcm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pcm_pkg::ctrl_t     ctrl,
  output pcm_pkg::stat_t     stat,
  input  pcm_pkg::in_item_t  in_item,
  input  logic [23:0]        parallel_cos,
  output logic               cmp_change,
  output pcm_pkg::out_item_t result
);
  import pcm_pkg::*;

  logic [1:0]         op, kind, count;
  logic signed [31:0] v [3];
  logic signed [31:0] dir [3];
  logic signed [63:0] prod [3];
  logic signed [65:0] dot;
  logic signed [31:0] crs [3];
  logic [63:0]        sq;
  // Square root unit.
  logic [63:0]        rt_v, rt_res, rt_bit;
  // Divider unit.
  logic [54:0]        dv_num;
  logic [54:0]        dv_q;
  logic [63:0]        dv_rem;
  logic [5:0]         dv_cnt;
  logic               unit_done;
  logic               cmp_fixed;
  logic signed [31:0] dsat;
  logic signed [31:0] mula, mulb;
  logic signed [63:0] mulp;
  logic signed [65:0] absdot;
  logic signed [25:0] one_m_pc;
  logic signed [65:0] pc_ext, ompc_ext;
  logic [31:0]        mag;

  assign stat.op = op;
  assign stat.kind = kind;
  assign stat.count = count;
  assign stat.unit_done = unit_done;

  // Shared multiplier: one 32x32 product per cycle, selected by lane.
  always_comb begin
    mula = v[ctrl.lane];
    mulb = dir[ctrl.lane];
    case (ctrl.cmd)
      CMD_CROSS: begin
        // With start_unit set a lane forms the minuend, without it the subtrahend.
        case (ctrl.lane)
          2'd0: begin
            mula = ctrl.start_unit ? dir[1] : dir[2];
            mulb = ctrl.start_unit ? v[2] : v[1];
          end
          2'd1: begin
            mula = ctrl.start_unit ? dir[2] : dir[0];
            mulb = ctrl.start_unit ? v[0] : v[2];
          end
          default: begin
            mula = ctrl.start_unit ? dir[0] : dir[1];
            mulb = ctrl.start_unit ? v[1] : v[0];
          end
        endcase
      end
      CMD_PROJ_MUL: begin mula = dsat; mulb = dir[ctrl.lane]; end
      default: ;
    endcase
    mulp = mula * mulb;
  end

  // Comparison of |dot| against the thresholds.
  always_comb begin
    absdot = dot[65] ? -dot : dot;
    one_m_pc = 26'sd8388608 - $signed({2'b00, parallel_cos});
    pc_ext = $signed({42'd0, parallel_cos});
    ompc_ext = 66'(one_m_pc);
    cmp_change = 1'b0;
    cmp_fixed = 1'b0;
    if (count == KIND_PLANE && kind == KIND_PLANE) begin
      cmp_change = absdot < pc_ext;
    end else if (count == KIND_PLANE && kind == KIND_LINE) begin
      cmp_change = 1'b1;
      cmp_fixed = absdot > ompc_ext;
    end else if (count == KIND_LINE && kind == KIND_PLANE) begin
      cmp_fixed = absdot > ompc_ext;
      cmp_change = cmp_fixed;
    end else begin
      cmp_fixed = absdot < pc_ext;
      cmp_change = cmp_fixed;
    end
  end

  assign dsat = sat32(dot);
  assign mag = crs[ctrl.lane][31] ? 32'(-crs[ctrl.lane]) : crs[ctrl.lane];

  // Registered datapath operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= KIND_FREE;
      for (int i = 0; i < 3; i++) dir[i] <= '0;
      unit_done <= 1'b0;
    end else begin
      unit_done <= 1'b0;
      case (ctrl.cmd)
        CMD_LOAD: begin
          op <= in_item.opcode;
          kind <= in_item.con_kind;
          v[0] <= in_item.vec_x;
          v[1] <= in_item.vec_y;
          v[2] <= in_item.vec_z;
          dot <= '0;
          sq <= '0;
        end
        CMD_MUL, CMD_PROJ_MUL: prod[ctrl.lane] <= mulp;
        CMD_DOT: dot <= 66'(prod[0] >>> FRAC_BITS) + 66'(prod[1] >>> FRAC_BITS)
                        + 66'(prod[2] >>> FRAC_BITS);
        CMD_CROSS: begin
          if (ctrl.start_unit) begin
            prod[ctrl.lane] <= mulp;
          end else begin
            crs[ctrl.lane] <= sat32(66'(prod[ctrl.lane] >>> FRAC_BITS)
                                    - 66'(mulp >>> FRAC_BITS));
          end
        end
        CMD_SQ: sq <= sq + 64'({32'd0, mag} * {32'd0, mag});
        CMD_SQRT: begin
          if (ctrl.start_unit) begin
            rt_v <= sq;
            rt_res <= '0;
            rt_bit <= 64'd1 << 62;
          end else if (rt_bit != 0) begin
            if (rt_v >= rt_res + rt_bit) begin
              rt_v <= rt_v - (rt_res + rt_bit);
              rt_res <= (rt_res >> 1) + rt_bit;
            end else begin
              rt_res <= rt_res >> 1;
            end
            rt_bit <= rt_bit >> 2;
          end else begin
            unit_done <= 1'b1;
          end
        end
        CMD_DIV: begin
          if (ctrl.start_unit) begin
            dv_num <= {mag, 23'd0};
            dv_rem <= '0;
            dv_q <= '0;
            dv_cnt <= 6'd55;
          end else if (dv_cnt != 0) begin
            if ({dv_rem[62:0], dv_num[54]} >= rt_res) begin
              dv_rem <= {dv_rem[62:0], dv_num[54]} - rt_res;
              dv_q <= {dv_q[53:0], 1'b1};
            end else begin
              dv_rem <= {dv_rem[62:0], dv_num[54]};
              dv_q <= {dv_q[53:0], 1'b0};
            end
            dv_num <= {dv_num[53:0], 1'b0};
            dv_cnt <= dv_cnt - 6'd1;
          end else begin
            unit_done <= 1'b1;
            prod[ctrl.lane] <= crs[ctrl.lane][31] ? -$signed({9'd0, dv_q})
                                                  : $signed({9'd0, dv_q});
          end
        end
        CMD_PROJ_OUT: begin
          for (int i = 0; i < 3; i++) begin
            if (count == KIND_PLANE) begin
              prod[i] <= 64'(sat32(66'(v[i]) - 66'(prod[i] >>> FRAC_BITS)));
            end else begin
              prod[i] <= 64'(sat32(66'(prod[i] >>> FRAC_BITS)));
            end
          end
        end
        CMD_COMMIT: begin
          if (op == OP_CLEAR) begin
            count <= KIND_FREE;
            for (int i = 0; i < 3; i++) dir[i] <= '0;
          end else if (op == OP_COMBINE && kind != KIND_FREE && count != KIND_FIXED) begin
            if (kind == KIND_FIXED) begin
              count <= KIND_FIXED;
              for (int i = 0; i < 3; i++) dir[i] <= '0;
            end else if (count == KIND_FREE) begin
              count <= kind;
              for (int i = 0; i < 3; i++) dir[i] <= v[i];
            end else if (cmp_fixed) begin
              count <= KIND_FIXED;
              for (int i = 0; i < 3; i++) dir[i] <= '0;
            end else if (cmp_change) begin
              count <= KIND_LINE;
              for (int i = 0; i < 3; i++) begin
                if (count == KIND_PLANE && kind == KIND_PLANE) begin
                  dir[i] <= (rt_res == 0) ? 32'sd0 : sat32(66'(prod[i]));
                end else begin
                  dir[i] <= v[i];
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result assembly for a projection.
  always_comb begin
    result.dof_removed = count;
    if (count == KIND_FREE) begin
      result.out_x = v[0];
      result.out_y = v[1];
      result.out_z = v[2];
    end else if (count == KIND_FIXED) begin
      result.out_x = '0;
      result.out_y = '0;
      result.out_z = '0;
    end else begin
      result.out_x = prod[0][31:0];
      result.out_y = prod[1][31:0];
      result.out_z = prod[2][31:0];
    end
  end

endmodule

// ===== src/pcm_ctrl.sv =====
// Controller state machine that sequences the point constraint datapath.
`timescale 1ns / 1ps
module pcm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic           cmp_change,
  input  pcm_pkg::stat_t stat,
  output pcm_pkg::ctrl_t ctrl
);
  import pcm_pkg::*;

  state_t     state, state_next;
  logic [1:0] lane, lane_next;
  logic       first, first_next;
  logic       pp;

  assign pp = (stat.count == KIND_PLANE) && (stat.kind == KIND_PLANE);

  // Next state logic.
  always_comb begin
    state_next = state;
    lane_next = lane;
    first_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
          lane_next = 2'd0;
        end
      end
      ST_MUL: begin
        lane_next = lane + 2'd1;
        if (lane == 2'd2) begin
          state_next = ST_DOT;
          lane_next = 2'd0;
        end
      end
      ST_DOT: state_next = ST_DECIDE;
      ST_DECIDE: begin
        lane_next = 2'd0;
        first_next = 1'b1;
        if (stat.op == OP_PROJECT) begin
          state_next = (stat.count == KIND_PLANE || stat.count == KIND_LINE) ? ST_PMUL : ST_OUT;
        end else if (stat.op == OP_COMBINE && pp && cmp_change) begin
          state_next = ST_CROSS;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CROSS: begin
        first_next = !first;
        if (!first) begin
          lane_next = lane + 2'd1;
          if (lane == 2'd2) begin
            state_next = ST_SQ;
            lane_next = 2'd0;
          end
        end
      end
      ST_SQ: begin
        lane_next = lane + 2'd1;
        first_next = 1'b1;
        if (lane == 2'd2) begin
          state_next = ST_SQRT;
          lane_next = 2'd0;
        end
      end
      // The done flag of the previous unit run is stale on a start cycle.
      ST_SQRT: begin
        if (stat.unit_done && !first) begin
          state_next = ST_DIV;
          first_next = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat.unit_done && !first) begin
          first_next = 1'b1;
          lane_next = lane + 2'd1;
          if (lane == 2'd2) begin
            state_next = ST_IDLE;
            lane_next = 2'd0;
          end
        end
      end
      ST_PMUL: begin
        lane_next = lane + 2'd1;
        if (lane == 2'd2) begin
          state_next = ST_POUT;
          lane_next = 2'd0;
        end
      end
      ST_POUT: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    ctrl.cmd = CMD_IDLE;
    ctrl.lane = lane;
    ctrl.start_unit = first;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) ctrl.cmd = CMD_LOAD;
      end
      ST_MUL: ctrl.cmd = CMD_MUL;
      ST_DOT: ctrl.cmd = CMD_DOT;
      ST_DECIDE: begin
        if (!(stat.op == OP_PROJECT) && !(stat.op == OP_COMBINE && pp && cmp_change)) begin
          ctrl.cmd = CMD_COMMIT;
        end
      end
      ST_CROSS: ctrl.cmd = CMD_CROSS;
      ST_SQ: ctrl.cmd = CMD_SQ;
      ST_SQRT: ctrl.cmd = CMD_SQRT;
      ST_DIV: begin
        ctrl.cmd = CMD_DIV;
        if (stat.unit_done && !first && lane == 2'd2) ctrl.cmd = CMD_COMMIT;
      end
      ST_PMUL: ctrl.cmd = CMD_PROJ_MUL;
      ST_POUT: ctrl.cmd = CMD_PROJ_OUT;
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lane <= 2'd0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      lane <= lane_next;
      first <= first_next;
    end
  end

endmodule

// ===== src/point_constraint_merge_project.sv =====
// Top level of the point constraint merge and project block.
//
// Usage: input items arrive on in_valid / in_stall with payload in_data.
// A transfer takes place when in_valid is high and in_stall is low.
// Combine and clear items change the stored constraint and give no result;
// a project item gives one result on out_valid / out_stall / out_data.
// The block works on one item at a time and is sequenced by a controller.
// Clear, combine without a cross product and unknown codes leave the block
// ready again without a result. Project goes straight to its result for
// free or fixed and through the projection multiply for a plane or a line;
// the block is ready the cycle after the result transfer. A plane merged
// with a non-parallel plane needs a cross product, a 32 step square root
// and three 55 step divisions; the square root and divider take longest.
// The parallel_cos register is written by cfg_valid / cfg_ready / cfg_data;
// cfg_ready is always high.
// Reset (rst, synchronous) clears the constraint to free with a zero
// direction and loads parallel_cos with its default. While the receiver
// stalls, the result holds and no new item is taken.
`timescale 1ns / 1ps
module point_constraint_merge_project #(
  parameter int unsigned COS_RESET = 8386930
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pcm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);
  import pcm_pkg::*;

  logic [23:0] parallel_cos;
  ctrl_t       ctrl;
  stat_t       stat;
  logic        cmp_change;

  assign cfg_ready = 1'b1;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) parallel_cos <= 24'(COS_RESET);
    else if (cfg_valid && cfg_ready) parallel_cos <= cfg_data;
  end

  pcm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmp_change, .stat, .ctrl
  );

  pcm_datapath u_dp (
    .clk, .rst, .ctrl, .stat, .in_item(in_data), .parallel_cos,
    .cmp_change, .result(out_data)
  );

endmodule

// ===== src/pcm_checker.sv =====
// Port checker for the point constraint block and its bind statement.
`timescale 1ns / 1ps
module pcm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pcm_pkg::out_item_t out_data
);
  import pcm_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input is never taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // A fixed result is all zero.
  a_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dof_removed == KIND_FIXED |->
      out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0)
    else $error("fixed constraint leaked motion");

  // An accepted item keeps the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after transfer");

endmodule

bind point_constraint_merge_project pcm_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

// ===== dv/tb_point_constraint_merge_project.sv =====
// Self-checking testbench for the point constraint merge and project block.
`timescale 1ns / 1ps
module tb_point_constraint_merge_project;
  import pcm_pkg::*;

  localparam int ONE_Q = 1 << 23;
  localparam int MAX_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;

  point_constraint_merge_project u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted constraint state and threshold.
  logic [23:0] cos_thr;
  logic [1:0] dof_cnt;
  logic signed [31:0] dir_vec [3];

  in_item_t pending_items[$];
  out_item_t expected_moves[$];
  int errors = 0;
  int cycles = 0;
  bit sender_hold = 1'b0;

  function automatic logic signed [63:0] fshift(input logic signed [63:0] p);
    return p >>> 23;
  endfunction

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] dot_q(input logic signed [31:0] a [3],
                                               input logic signed [31:0] b [3]);
    logic signed [63:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += fshift(64'(a[i]) * 64'(b[i]));
    return s;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Line direction from two plane normals: normalized cross product.
  task automatic plane_intersection(input logic signed [31:0] a [3],
                                    input logic signed [31:0] b [3]);
    logic signed [63:0] c [3];
    logic [63:0] sq, n, m, q;
    c[0] = clip32(fshift(64'(a[1]) * 64'(b[2])) - fshift(64'(a[2]) * 64'(b[1])));
    c[1] = clip32(fshift(64'(a[2]) * 64'(b[0])) - fshift(64'(a[0]) * 64'(b[2])));
    c[2] = clip32(fshift(64'(a[0]) * 64'(b[1])) - fshift(64'(a[1]) * 64'(b[0])));
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m = c[i] < 0 ? -c[i] : c[i];
      sq += m * m;
    end
    n = root64(sq);
    for (int i = 0; i < 3; i++) begin
      m = c[i] < 0 ? -c[i] : c[i];
      if (n == 0) dir_vec[i] = 0;
      else begin
        q = (m << 23) / n;
        dir_vec[i] = 32'(clip32(c[i] < 0 ? -$signed(q) : $signed(q)));
      end
    end
  endtask

  task automatic go_fixed();
    dof_cnt = KIND_FIXED;
    for (int i = 0; i < 3; i++) dir_vec[i] = 0;
  endtask

  // Apply one item to the predicted state and queue any expected result.
  task automatic predict_item(input in_item_t it);
    logic signed [31:0] v [3];
    logic signed [63:0] c, pc, d, term;
    out_item_t r;
    v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
    pc = 64'(cos_thr);
    case (it.opcode)
      OP_COMBINE: begin
        if (it.con_kind == KIND_FREE || dof_cnt == KIND_FIXED) ;
        else if (it.con_kind == KIND_FIXED) go_fixed();
        else if (dof_cnt == KIND_FREE) begin
          dof_cnt = it.con_kind;
          dir_vec = v;
        end else begin
          c = dot_q(dir_vec, v);
          if (c < 0) c = -c;
          if (dof_cnt == KIND_PLANE && it.con_kind == KIND_PLANE) begin
            if (c < pc) begin
              plane_intersection(dir_vec, v);
              dof_cnt = KIND_LINE;
            end
          end else if (dof_cnt == KIND_PLANE) begin
            if (c <= ONE_Q - pc) begin
              dof_cnt = KIND_LINE;
              dir_vec = v;
            end else go_fixed();
          end else if (it.con_kind == KIND_PLANE) begin
            if (c > ONE_Q - pc) go_fixed();
          end else begin
            if (c < pc) go_fixed();
          end
        end
      end
      OP_CLEAR: begin
        dof_cnt = KIND_FREE;
        for (int i = 0; i < 3; i++) dir_vec[i] = 0;
      end
      OP_PROJECT: begin
        r.dof_removed = dof_cnt;
        if (dof_cnt == KIND_FREE) begin
          r.out_x = v[0]; r.out_y = v[1]; r.out_z = v[2];
        end else if (dof_cnt == KIND_FIXED) begin
          r.out_x = 0; r.out_y = 0; r.out_z = 0;
        end else begin
          d = clip32(dot_q(v, dir_vec));
          for (int i = 0; i < 3; i++) begin
            term = fshift(d * 64'(dir_vec[i]));
            v[i] = 32'(clip32(dof_cnt == KIND_PLANE ? 64'(v[i]) - term : term));
          end
          r.out_x = v[0]; r.out_y = v[1]; r.out_z = v[2];
        end
        expected_moves.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_unit_comp();
    return $signed(32'($urandom_range(0, 2 * ONE_Q))) - ONE_Q;
  endfunction

  // Roughly unit vector: one dominant axis plus random tilt.
  function automatic in_item_t dir_item(input logic [1:0] kind);
    in_item_t it;
    logic signed [31:0] small_a, small_b, big;
    it.opcode = OP_COMBINE;
    it.con_kind = kind;
    small_a = rand_unit_comp() >>> $urandom_range(0, 4);
    small_b = rand_unit_comp() >>> $urandom_range(0, 4);
    big = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
    case ($urandom_range(0, 2))
      0: begin it.vec_x = big; it.vec_y = small_a; it.vec_z = small_b; end
      1: begin it.vec_x = small_a; it.vec_y = big; it.vec_z = small_b; end
      default: begin it.vec_x = small_a; it.vec_y = small_b; it.vec_z = big; end
    endcase
    return it;
  endfunction

  function automatic in_item_t raw_item(input logic [1:0] op, input logic [1:0] kind);
    in_item_t it;
    it.opcode = op;
    it.con_kind = kind;
    it.vec_x = $urandom;
    it.vec_y = $urandom;
    it.vec_z = $urandom;
    if ($urandom_range(0, 2) != 0) begin
      it.vec_x = it.vec_x >>> $urandom_range(0, 28);
      it.vec_y = it.vec_y >>> $urandom_range(0, 28);
      it.vec_z = it.vec_z >>> $urandom_range(0, 28);
    end
    return it;
  endfunction

  function automatic in_item_t proj_item();
    return raw_item(OP_PROJECT, $urandom);
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input logic [1:0] kind,
                                  input int x, input int y, input int z);
    in_item_t it;
    it.opcode = op; it.con_kind = kind;
    it.vec_x = x; it.vec_y = y; it.vec_z = z;
    return it;
  endfunction

  // Driver: presents queued items with random gaps; the receiver stalls
  // each result for a randomly drawn number of cycles.
  int in_gap = 0;
  int out_gap = 0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_took) ;
      else begin
        if (in_took) begin
          in_took = 1'b0;
          in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        end
        if (in_gap > 0 || sender_hold || pending_items.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end
      end
      if (out_took) begin
        out_took = 1'b0;
        out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (out_valid && out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each input transfer and compares each result
  // transfer with the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && !in_stall) begin
      predict_item(in_data);
      void'(pending_items.pop_front());
      in_took = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      out_took = 1'b1;
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        errors <= errors + 1;
      end else begin
        if (out_data !== expected_moves[0]) begin
          $display("%0t: mismatch expected %h actual %h", $time,
                   expected_moves[0], out_data);
          errors <= errors + 1;
        end
        void'(expected_moves.pop_front());
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > MAX_CYCLES) begin
      $display("tb_point_constraint_merge_project NOT OK");
      $finish;
    end
  end

  // Wait until every queued item has gone and every result came back.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_moves.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cos(input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cos_thr = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        pending_items.push_back(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
        for (int j = $urandom_range(1, 3); j > 0; j--)
          pending_items.push_back(dir_item($urandom_range(0, 3) == 0 ?
                                            $urandom : ($urandom_range(1, 2))));
        pending_items.push_back(proj_item());
      end else if (r < 75) pending_items.push_back(proj_item());
      else if (r < 90) pending_items.push_back(raw_item(OP_COMBINE, $urandom));
      else pending_items.push_back(raw_item($urandom, $urandom));
    end
  endtask

  logic [23:0] cos_set [5] = '{24'd8386930, 24'd0, 24'hFFFFFF, 24'd8388608, 24'd5000000};

  initial begin
    cos_thr = 24'd8386930;
    dof_cnt = KIND_FREE;
    for (int i = 0; i < 3; i++) dir_vec[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every opcode, several combine paths, degenerate cross.
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, 32'h7fffffff, 32'h80000000, -1));
    pending_items.push_back(mk(OP_NONE, KIND_PLANE, 1, 2, 3));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, 0, 0, ONE_Q));
    pending_items.push_back(mk(OP_COMBINE, KIND_FREE, ONE_Q, 0, 0));
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, 0, 0, -ONE_Q));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, ONE_Q, 0, 0));
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, ONE_Q, ONE_Q, ONE_Q));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, 0, ONE_Q, 0));
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, ONE_Q, ONE_Q, ONE_Q));
    pending_items.push_back(mk(OP_COMBINE, KIND_LINE, 0, ONE_Q, 0));
    pending_items.push_back(mk(OP_COMBINE, KIND_LINE, ONE_Q, 0, 0));
    pending_items.push_back(mk(OP_PROJECT, KIND_LINE, -1, -1, -1));
    pending_items.push_back(mk(OP_COMBINE, KIND_FIXED, 0, 0, 0));
    pending_items.push_back(mk(OP_CLEAR, KIND_FIXED, 0, 0, 0));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, 5, 0, 0));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, 0, 0, 0));
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, 7, 7, 7));
    pending_items.push_back(mk(OP_CLEAR, KIND_FREE, 0, 0, 0));
    pending_items.push_back(mk(OP_COMBINE, KIND_LINE, 0, 0, ONE_Q));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, ONE_Q, 0, 0));
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    pending_items.push_back(mk(OP_COMBINE, KIND_PLANE, 0, 0, ONE_Q));
    pending_items.push_back(mk(OP_PROJECT, KIND_FREE, ONE_Q, ONE_Q, ONE_Q));
    drain();

    // Random phases over several thresholds, extremes included.
    for (int p = 0; p < 5; p++) begin
      write_cos(cos_set[p]);
      random_phase(50);
      if (p == 2) begin
        // Sender holds off until every result has come back.
        sender_hold = 1'b1;
        while (expected_moves.size() != 0 || in_valid) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("tb_point_constraint_merge_project OK");
    else $display("tb_point_constraint_merge_project NOT OK");
    $finish;
  end
endmodule

// ===== point_constraint_merge_project.f =====
src/pcm_pkg.sv
src/pcm_datapath.sv
src/pcm_ctrl.sv
src/point_constraint_merge_project.sv
src/pcm_checker.sv
dv/tb_point_constraint_merge_project.sv
